// ===== sv/rmq_pkg.sv =====
`timescale 1ns / 1ps
// Types and fixed constants for the rotation matrix to quaternion block.
// No dependencies; used by rmq_sqrt, rmq_div and the top level.
package rmq_pkg;

    localparam int PRESCALE_LIMIT = 20;
    localparam int NORM_GUARD     = 10;
    localparam int SUM_W          = 2 * PRESCALE_LIMIT + 2;
    localparam int RAD_N_W        = SUM_W + 2 * NORM_GUARD;
    localparam int ROOT_W         = RAD_N_W / 2;
    localparam int LANES          = 4;

    typedef logic [PRESCALE_LIMIT-1:0] smag_t;

    typedef struct packed {
        logic signed [15:0] elem_r0c0;
        logic signed [15:0] elem_r0c1;
        logic signed [15:0] elem_r0c2;
        logic signed [15:0] elem_r1c0;
        logic signed [15:0] elem_r1c1;
        logic signed [15:0] elem_r1c2;
        logic signed [15:0] elem_r2c0;
        logic signed [15:0] elem_r2c1;
        logic signed [15:0] elem_r2c2;
    } rmq_in_t;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic               invalid;
    } rmq_out_t;

    // Data that rides along the square root and divide pipelines.
    typedef struct packed {
        logic                   invalid;
        logic [LANES-1:0]       neg;
        smag_t [LANES-1:0]      mag;
    } rmq_side_t;

endpackage

// ===== sv/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
// Rotation matrix to unit quaternion converter (Shepperd branch selection).
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
//
// A request is taken on every clock edge where start is high; busy never
// rises, so one matrix per cycle streams in. Each request produces exactly
// one result, shown on quat with done high for one cycle. The pipeline is
// made of the square root stages (one stage per root bit, 31 stages) and
// the divider stages (FRAC_BITS + 2 stages), plus six stages of branch
// select, magnitude, prescale, square, sum and saturation. The receiver
// must take every result in the cycle it is shown. A non-positive
// radicand gives invalid = 1 and all components zero.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rmq_pkg::rmq_in_t  matrix,
    output logic              done,
    output rmq_pkg::rmq_out_t quat
);
    import rmq_pkg::*;

    localparam int HI_W  = (FRAC_BITS > 17) ? FRAC_BITS : 17;
    localparam int RAD_W = HI_W + 3;
    localparam int MAG_W = RAD_W - 1;
    localparam int SH_W  = $clog2(MAG_W + 1);
    localparam int EXT_W = (MAG_W > PRESCALE_LIMIT) ? MAG_W : PRESCALE_LIMIT;
    localparam int QB    = FRAC_BITS + 1;
    localparam int QX_W  = (QB > 17) ? QB : 17;
    localparam int LAT   = 5 + ROOT_W + QB + 2;
    localparam logic signed [RAD_W-1:0] ONE = RAD_W'(1) << FRAC_BITS;

    assign busy = 1'b0;

    // ---------------- stage 1: branch select ----------------
    logic signed [RAD_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [RAD_W-1:0] trace, rad;
    logic signed [RAD_W-1:0] v1_next [LANES];
    logic signed [RAD_W-1:0] v1_reg  [LANES];
    logic                    inv1_reg;
    logic                    valid1_reg;

    assign a00 = RAD_W'(matrix.elem_r0c0);
    assign a01 = RAD_W'(matrix.elem_r0c1);
    assign a02 = RAD_W'(matrix.elem_r0c2);
    assign a10 = RAD_W'(matrix.elem_r1c0);
    assign a11 = RAD_W'(matrix.elem_r1c1);
    assign a12 = RAD_W'(matrix.elem_r1c2);
    assign a20 = RAD_W'(matrix.elem_r2c0);
    assign a21 = RAD_W'(matrix.elem_r2c1);
    assign a22 = RAD_W'(matrix.elem_r2c2);
    assign trace = a00 + a11 + a22;

    // lanes are x, y, z, w
    always_comb
    begin
        if (!trace[RAD_W-1] && (trace != '0))
        begin
            rad        = ONE + trace;
            v1_next[3] = rad;
            v1_next[0] = a21 - a12;
            v1_next[1] = a02 - a20;
            v1_next[2] = a10 - a01;
        end
        else if ((a00 > a11) && (a00 > a22))
        begin
            rad        = ONE + a00 - a11 - a22;
            v1_next[0] = rad;
            v1_next[3] = a21 - a12;
            v1_next[1] = a01 + a10;
            v1_next[2] = a02 + a20;
        end
        else if (a11 > a22)
        begin
            rad        = ONE + a11 - a00 - a22;
            v1_next[1] = rad;
            v1_next[3] = a02 - a20;
            v1_next[0] = a01 + a10;
            v1_next[2] = a12 + a21;
        end
        else
        begin
            rad        = ONE + a22 - a00 - a11;
            v1_next[2] = rad;
            v1_next[3] = a10 - a01;
            v1_next[0] = a02 + a20;
            v1_next[1] = a12 + a21;
        end
    end

    // ---------------- stage 2: magnitudes ----------------
    logic [MAG_W-1:0] mag2_reg [LANES];
    logic [LANES-1:0] neg2_reg;
    logic [MAG_W-1:0] or2_reg;
    logic             inv2_reg;
    logic             valid2_reg;
    logic [MAG_W-1:0] mag2_next [LANES];
    logic [MAG_W-1:0] or2_next;

    always_comb
    begin
        or2_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            mag2_next[i] = v1_reg[i][RAD_W-1] ? MAG_W'(-v1_reg[i]) : MAG_W'(v1_reg[i]);
            or2_next     = or2_next | mag2_next[i];
        end
    end

    // ---------------- stage 3: prescale ----------------
    logic [SH_W-1:0]  len3;
    logic [SH_W-1:0]  sh3;
    logic [EXT_W-1:0] ext3;
    smag_t            mag3_next [LANES];
    smag_t            mag3_reg  [LANES];
    logic [LANES-1:0] neg3_reg;
    logic             inv3_reg;
    logic             valid3_reg;

    always_comb
    begin
        len3 = '0;
        for (int b = 0; b < MAG_W; b++)
        begin
            if (or2_reg[b])
            begin
                len3 = SH_W'(b + 1);
            end
        end
        sh3 = (len3 > SH_W'(PRESCALE_LIMIT)) ? (len3 - SH_W'(PRESCALE_LIMIT)) : '0;
        for (int i = 0; i < LANES; i++)
        begin
            ext3         = EXT_W'(mag2_reg[i]) >> sh3;
            mag3_next[i] = ext3[PRESCALE_LIMIT-1:0];
        end
    end

    // ---------------- stage 4: squares, stage 5: sum ----------------
    logic [2*PRESCALE_LIMIT-1:0] sq4_reg [LANES];
    smag_t                       mag4_reg [LANES];
    logic [LANES-1:0]            neg4_reg;
    logic                        inv4_reg;
    logic                        valid4_reg;
    logic [SUM_W-1:0]            sum5_reg;
    rmq_side_t                   side5_reg;
    logic                        valid5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= start;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
            valid5_reg <= valid4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        v1_reg   <= v1_next;
        inv1_reg <= rad[RAD_W-1] || (rad == '0);

        mag2_reg <= mag2_next;
        or2_reg  <= or2_next;
        inv2_reg <= inv1_reg;
        for (int i = 0; i < LANES; i++)
        begin
            neg2_reg[i] <= v1_reg[i][RAD_W-1];
        end

        mag3_reg <= mag3_next;
        neg3_reg <= neg2_reg;
        inv3_reg <= inv2_reg;

        for (int i = 0; i < LANES; i++)
        begin
            sq4_reg[i] <= (2*PRESCALE_LIMIT)'(mag3_reg[i]) * (2*PRESCALE_LIMIT)'(mag3_reg[i]);
        end
        mag4_reg <= mag3_reg;
        neg4_reg <= neg3_reg;
        inv4_reg <= inv3_reg;

        sum5_reg <= SUM_W'(sq4_reg[0]) + SUM_W'(sq4_reg[1])
                  + SUM_W'(sq4_reg[2]) + SUM_W'(sq4_reg[3]);
        side5_reg.invalid <= inv4_reg;
        side5_reg.neg     <= neg4_reg;
        for (int i = 0; i < LANES; i++)
        begin
            side5_reg.mag[i] <= mag4_reg[i];
        end
    end

    // ---------------- square root and divide ----------------
    logic                      valid_s;
    logic [ROOT_W-1:0]         root_s;
    rmq_side_t                 side_s;
    logic                      valid_d;
    logic [LANES-1:0][QB-1:0]  quot_d;
    rmq_side_t                 side_d;

    rmq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid5_reg),
        .sum       (sum5_reg),
        .in_side   (side5_reg),
        .out_valid (valid_s),
        .root      (root_s),
        .out_side  (side_s)
    );

    rmq_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_s),
        .root      (root_s),
        .in_side   (side_s),
        .out_valid (valid_d),
        .quot      (quot_d),
        .out_side  (side_d)
    );

    // ---------------- final: sign, saturate ----------------
    logic signed [15:0] comp [LANES];
    logic [QX_W-1:0]    qx;
    logic               done_reg;
    rmq_out_t           quat_reg;
    rmq_out_t           quat_next;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            qx = QX_W'(quot_d[i]);
            if (side_d.invalid)
            begin
                comp[i] = '0;
            end
            else if (side_d.neg[i])
            begin
                comp[i] = (qx > QX_W'(32768)) ? 16'sh8000 : 16'(-qx);
            end
            else
            begin
                comp[i] = (qx > QX_W'(32767)) ? 16'sh7fff : 16'(qx);
            end
        end
        quat_next.quat_x  = comp[0];
        quat_next.quat_y  = comp[1];
        quat_next.quat_z  = comp[2];
        quat_next.quat_w  = comp[3];
        quat_next.invalid = side_d.invalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_d;
        end
    end

    always_ff @(posedge clk)
    begin
        quat_reg <= quat_next;
    end

    assign done = done_reg;
    assign quat = quat_reg;

    // ---------------- assertions ----------------
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("request did not produce a result at the pipeline latency");

    a_no_orphan : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching request");

    a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && quat.invalid) |-> ((quat.quat_x == '0) && (quat.quat_y == '0)
                                    && (quat.quat_z == '0) && (quat.quat_w == '0)))
        else $error("invalid result with nonzero components");

endmodule

// ===== sv/rmq_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per register stage.
// Depends on rmq_pkg.
module rmq_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [rmq_pkg::SUM_W-1:0] sum,
    input  rmq_pkg::rmq_side_t        in_side,
    output logic                      out_valid,
    output logic [rmq_pkg::ROOT_W-1:0] root,
    output rmq_pkg::rmq_side_t        out_side
);
    import rmq_pkg::*;

    localparam int STAGES = ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    logic [STAGES-1:0]  valid_reg;
    logic [REM_W-1:0]   rem_reg   [STAGES];
    logic [REM_W-1:0]   rem_next  [STAGES];
    logic [ROOT_W-1:0]  root_reg  [STAGES];
    logic [ROOT_W-1:0]  root_next [STAGES];
    logic [RAD_N_W-1:0] rad_reg   [STAGES];
    logic [RAD_N_W-1:0] rad_next  [STAGES];
    rmq_side_t          side_reg  [STAGES];
    rmq_side_t          side_next [STAGES];

    always_comb
    begin
        logic [REM_W-1:0]   rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [RAD_N_W-1:0] rad_in;
        logic [REM_W-1:0]   rem_sh;
        logic [REM_W-1:0]   trial;
        for (int j = 0; j < STAGES; j++)
        begin
            if (j == 0)
            begin
                rem_in       = '0;
                root_in      = '0;
                rad_in       = {sum, {(2 * NORM_GUARD){1'b0}}};
                side_next[j] = in_side;
            end
            else
            begin
                rem_in       = rem_reg[j-1];
                root_in      = root_reg[j-1];
                rad_in       = rad_reg[j-1];
                side_next[j] = side_reg[j-1];
            end
            // bring down the next pair of radicand bits
            rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_N_W-1 -: 2]};
            trial  = {root_in, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next[j]  = rem_sh - trial;
                root_next[j] = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[j]  = rem_sh;
                root_next[j] = {root_in[ROOT_W-2:0], 1'b0};
            end
            rad_next[j] = rad_in << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
        side_reg <= side_next;
    end

    assign out_valid = valid_reg[STAGES-1];
    assign root      = root_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ===== sv/rmq_div.sv =====
`timescale 1ns / 1ps
// Four-lane pipelined restoring divider with rounding, one quotient bit per stage
// after the load stage. Depends on rmq_pkg.
module rmq_div #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    input  logic [rmq_pkg::ROOT_W-1:0]                    root,
    input  rmq_pkg::rmq_side_t                            in_side,
    output logic                                          out_valid,
    output logic [rmq_pkg::LANES-1:0][FRAC_BITS:0]        quot,
    output rmq_pkg::rmq_side_t                            out_side
);
    import rmq_pkg::*;

    localparam int QB     = FRAC_BITS + 1;
    localparam int NUM_W  = PRESCALE_LIMIT + FRAC_BITS + NORM_GUARD + 1;
    localparam int R_W    = ROOT_W + 1;
    localparam int STAGES = QB + 1;

    logic [STAGES-1:0] valid_reg;
    logic [R_W-1:0]    rem_reg   [STAGES][LANES];
    logic [R_W-1:0]    rem_next  [STAGES][LANES];
    logic [QB-1:0]     lo_reg    [STAGES][LANES];
    logic [QB-1:0]     lo_next   [STAGES][LANES];
    logic [QB-1:0]     q_reg     [STAGES][LANES];
    logic [QB-1:0]     q_next    [STAGES][LANES];
    logic [ROOT_W-1:0] m_reg     [STAGES];
    logic [ROOT_W-1:0] m_next    [STAGES];
    rmq_side_t         side_reg  [STAGES];
    rmq_side_t         side_next [STAGES];

    always_comb
    begin
        logic [NUM_W-1:0] num;
        logic [R_W-1:0]   rs;
        for (int j = 0; j < STAGES; j++)
        begin
            if (j == 0)
            begin
                m_next[j]    = root;
                side_next[j] = in_side;
                for (int i = 0; i < LANES; i++)
                begin
                    // numerator with half the divisor added for rounding
                    num = (NUM_W'(in_side.mag[i]) << (FRAC_BITS + NORM_GUARD))
                        + NUM_W'(root >> 1);
                    rem_next[j][i] = R_W'(num >> QB);
                    lo_next[j][i]  = num[QB-1:0];
                    q_next[j][i]   = '0;
                end
            end
            else
            begin
                m_next[j]    = m_reg[j-1];
                side_next[j] = side_reg[j-1];
                for (int i = 0; i < LANES; i++)
                begin
                    rs = {rem_reg[j-1][i][R_W-2:0], lo_reg[j-1][i][QB-1]};
                    if (rs >= R_W'(m_reg[j-1]))
                    begin
                        rem_next[j][i] = rs - R_W'(m_reg[j-1]);
                        q_next[j][i]   = {q_reg[j-1][i][QB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[j][i] = rs;
                        q_next[j][i]   = {q_reg[j-1][i][QB-2:0], 1'b0};
                    end
                    lo_next[j][i] = lo_reg[j-1][i] << 1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        q_reg    <= q_next;
        m_reg    <= m_next;
        side_reg <= side_next;
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            quot[i] = q_reg[STAGES-1][i];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ===== dv/rmq_checker.sv =====
`timescale 1ns / 1ps
// Checker for the rotation matrix to quaternion block: watches requests and
// results, predicts each quaternion and compares. Depends on rmq_pkg.
module rmq_checker #(
    parameter int FRAC_BITS = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  rmq_pkg::rmq_in_t  matrix,
    input  logic              done,
    input  rmq_pkg::rmq_out_t quat,
    output int                fail_count,
    output int                pending
);
    import rmq_pkg::*;

    rmq_out_t quat_fifo[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic rmq_out_t predict_quat(rmq_in_t mx);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
        longint one, tr, rad;
        longint v[4];
        longint unsigned mg[4];
        longint unsigned maxmag, sum, m, q;
        logic signed [15:0] comp[4];
        int sh;
        rmq_out_t r;
        a00 = mx.elem_r0c0; a01 = mx.elem_r0c1; a02 = mx.elem_r0c2;
        a10 = mx.elem_r1c0; a11 = mx.elem_r1c1; a12 = mx.elem_r1c2;
        a20 = mx.elem_r2c0; a21 = mx.elem_r2c1; a22 = mx.elem_r2c2;
        one = longint'(1) << FRAC_BITS;
        tr = a00 + a11 + a22;
        r = '0;
        // v holds x, y, z, w
        if (tr > 0)
        begin
            rad = one + tr;
            v[3] = rad; v[0] = a21 - a12; v[1] = a02 - a20; v[2] = a10 - a01;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            rad = one + a00 - a11 - a22;
            v[0] = rad; v[3] = a21 - a12; v[1] = a01 + a10; v[2] = a02 + a20;
        end
        else if (a11 > a22)
        begin
            rad = one + a11 - a00 - a22;
            v[1] = rad; v[3] = a02 - a20; v[0] = a01 + a10; v[2] = a12 + a21;
        end
        else
        begin
            rad = one + a22 - a00 - a11;
            v[2] = rad; v[3] = a10 - a01; v[0] = a02 + a20; v[1] = a12 + a21;
        end
        if (rad <= 0)
        begin
            r.invalid = 1'b1;
            return r;
        end
        maxmag = 0;
        for (int i = 0; i < 4; i++)
        begin
            mg[i] = (v[i] < 0) ? -v[i] : v[i];
            if (mg[i] > maxmag)
                maxmag = mg[i];
        end
        sh = 0;
        while ((maxmag >> sh) >= (64'd1 << PRESCALE_LIMIT))
            sh++;
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            mg[i] >>= sh;
            sum += mg[i] * mg[i];
        end
        m = int_sqrt(sum << (2 * NORM_GUARD));
        for (int i = 0; i < 4; i++)
        begin
            q = ((mg[i] << (FRAC_BITS + NORM_GUARD)) + (m >> 1)) / m;
            if (v[i] < 0)
                comp[i] = (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
            else
                comp[i] = (q > 32767) ? 16'sd32767 : 16'(q);
        end
        r.quat_x = comp[0];
        r.quat_y = comp[1];
        r.quat_z = comp[2];
        r.quat_w = comp[3];
        return r;
    endfunction

    assign pending = quat_fifo.size();

    always @(posedge clk or negedge rst_n)
    begin
        rmq_out_t exp_q;
        if (!rst_n)
        begin
            fail_count <= 0;
            quat_fifo.delete();
        end
        else
        begin
            if (start && !busy)
                quat_fifo.push_back(predict_quat(matrix));
            if (done)
            begin
                if (quat_fifo.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_q = quat_fifo.pop_front();
                    if (quat !== exp_q)
                    begin
                        fail_count <= fail_count + 1;
                        if (quat.quat_x !== exp_q.quat_x)
                            $error("quat_x exp %0d got %0d", exp_q.quat_x, quat.quat_x);
                        if (quat.quat_y !== exp_q.quat_y)
                            $error("quat_y exp %0d got %0d", exp_q.quat_y, quat.quat_y);
                        if (quat.quat_z !== exp_q.quat_z)
                            $error("quat_z exp %0d got %0d", exp_q.quat_z, quat.quat_z);
                        if (quat.quat_w !== exp_q.quat_w)
                            $error("quat_w exp %0d got %0d", exp_q.quat_w, quat.quat_w);
                        if (quat.invalid !== exp_q.invalid)
                            $error("invalid exp %0b got %0b", exp_q.invalid, quat.invalid);
                    end
                end
            end
        end
    end
endmodule

// ===== dv/rotation_matrix_to_quaternion_tb.sv =====
`timescale 1ns / 1ps
// Top of the rotation matrix to quaternion testbench: clock, reset, request
// stimulus and verdict. Depends on rmq_pkg, the block and rmq_checker.
module rotation_matrix_to_quaternion_tb;
    import rmq_pkg::*;

    localparam int FRAC_BITS = 14;
    localparam int LATENCY   = FRAC_BITS + 39;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int IDLE_LIMIT = 2000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    rmq_in_t  matrix;
    logic     done;
    rmq_out_t quat;
    int       fail_count;
    int       pending;
    int       idle_cycles;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC_BITS)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .matrix(matrix), .done(done), .quat(quat)
    );

    rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .matrix(matrix),
        .done(done), .quat(quat), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Count cycles with nothing accepted and no result; end the run on a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("rotation_matrix_to_quaternion_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 2 * ONE)) - 16'(ONE);
            2: return 16'(ONE);
            3: return 16'(-ONE);
            4: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    // Rotation-like matrix: diagonal chosen to steer toward a given branch.
    function automatic rmq_in_t rand_rotation(int branch);
        rmq_in_t mx;
        int bigv, lowv;
        mx.elem_r0c1 = 16'($urandom_range(0, ONE) - ONE / 2);
        mx.elem_r0c2 = 16'($urandom_range(0, ONE) - ONE / 2);
        mx.elem_r1c0 = 16'($urandom_range(0, ONE) - ONE / 2);
        mx.elem_r1c2 = 16'($urandom_range(0, ONE) - ONE / 2);
        mx.elem_r2c0 = 16'($urandom_range(0, ONE) - ONE / 2);
        mx.elem_r2c1 = 16'($urandom_range(0, ONE) - ONE / 2);
        bigv = $urandom_range(0, ONE);
        lowv = -int'($urandom_range(0, ONE));
        mx.elem_r0c0 = 16'(lowv);
        mx.elem_r1c1 = 16'(lowv + int'($urandom_range(0, 2)) - 1);
        mx.elem_r2c2 = 16'(lowv);
        case (branch)
            0: begin
                mx.elem_r0c0 = 16'(bigv); mx.elem_r1c1 = 16'(bigv);
                mx.elem_r2c2 = 16'(bigv);
            end
            1: mx.elem_r0c0 = 16'(bigv);
            2: mx.elem_r1c1 = 16'(bigv);
            default: mx.elem_r2c2 = 16'(bigv);
        endcase
        return mx;
    endfunction

    task automatic send_request(rmq_in_t mx);
        start  <= 1'b1;
        matrix <= mx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 2) != 0)
            return;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    initial
    begin
        rmq_in_t mx;
        int guard;
        rst_n  = 1'b0;
        start  = 1'b0;
        matrix = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, half turns, all-zero, extreme and patterned matrices.
        mx = '0; mx.elem_r0c0 = 16'(ONE); mx.elem_r1c1 = 16'(ONE); mx.elem_r2c2 = 16'(ONE);
        send_request(mx);
        mx = '0; mx.elem_r0c0 = 16'(ONE); mx.elem_r1c1 = 16'(-ONE); mx.elem_r2c2 = 16'(-ONE);
        send_request(mx);
        mx = '0; mx.elem_r0c0 = 16'(-ONE); mx.elem_r1c1 = 16'(ONE); mx.elem_r2c2 = 16'(-ONE);
        send_request(mx);
        mx = '0; mx.elem_r0c0 = 16'(-ONE); mx.elem_r1c1 = 16'(-ONE); mx.elem_r2c2 = 16'(ONE);
        send_request(mx);
        send_request('0);
        send_request({9{16'h7fff}});
        send_request({9{16'h8000}});
        send_request({9{16'hffff}});
        mx = {9{16'h8000}}; mx.elem_r0c0 = 16'h7fff;
        send_request(mx);
        mx = {9{16'h7fff}}; mx.elem_r1c1 = 16'h8000; mx.elem_r2c2 = 16'h8000;
        send_request(mx);
        mx = '0; mx.elem_r0c0 = 16'(-ONE); mx.elem_r1c1 = 16'(-ONE); mx.elem_r2c2 = 16'(-ONE);
        send_request(mx);
        // Equal diagonals: ties fall through to the last branch.
        mx = '0; mx.elem_r0c0 = 16'(-ONE / 2); mx.elem_r1c1 = 16'(-ONE / 2);
        mx.elem_r2c2 = 16'(-ONE / 2);
        send_request(mx);
        mx = {16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
              16'haaaa, 16'h5555, 16'haaaa, 16'h5555};
        send_request(mx);
        mx = ~mx;
        send_request(mx);

        // Hold off until the pipeline drains.
        start <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 10 * LATENCY)
        begin
            @(posedge clk);
            guard++;
        end

        for (int i = 0; i < 1650; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                for (int k = 0; k < 9; k++)
                    mx[16*k +: 16] = rand_elem();
            end
            else
                mx = rand_rotation($urandom_range(0, 3));
            send_request(mx);
            if ((i / 200) % 2 == 1)
                idle_gap();
        end
        start <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 20 * LATENCY)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("rotation_matrix_to_quaternion_tb OK");
        else
            $display("rotation_matrix_to_quaternion_tb NOT OK");
        $finish;
    end
endmodule

// ===== rotation_matrix_to_quaternion.f =====
sv/rmq_pkg.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion.sv
dv/rmq_checker.sv
dv/rotation_matrix_to_quaternion_tb.sv
